FILE: design/sync_header_crc_frame_parser_macros.svh
// Assertion macros for the sync header CRC frame parser.
// Used by the top level; expects clk and rst in scope.
`ifndef SYNC_HEADER_CRC_FRAME_PARSER_MACROS_SVH
`define SYNC_HEADER_CRC_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SHCFP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SHCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/shcfp_pkg.sv
// Shared types, constants and the bytewise CRC16 function of the frame parser.
// No dependencies; imported by shcfp_core and the top level.
package shcfp_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int HDR_CNT_W    = 4;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_LO  = 3'd4,
    PH_CRC_HI  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_OK        = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_WRONG_TYP = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_BAD_CRC   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CFG_SYNC_FIRST  = 3'd0,
    CFG_SYNC_SECOND = 3'd1,
    CFG_VERSION     = 3'd2,
    CFG_TYPE        = 3'd3,
    CFG_MAX_PAYLOAD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  protocol_version;
    logic [7:0]  allowed_kind;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  version;
    logic [7:0]  msg_kind;
    logic [7:0]  peripheral;
    logic [7:0]  res_code;
    logic [15:0] command_code;
    logic [31:0] req_tag;
    logic [15:0] body_len;
  } result_t;

  // CRC16-CCITT, MSB first, one byte per call.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: design/shcfp_core.sv
// Frame parser state machine, header store and running CRC.
// Produces the result for the byte accepted this cycle; uses shcfp_pkg.
module shcfp_core
  import shcfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    result
);

  phase_t                 phase, phase_next;
  logic [HDR_CNT_W-1:0]   header_count;
  logic [7:0]             header_store [HEADER_BYTES];
  logic [15:0]            payload_count;
  logic [7:0]             crc_low_byte;
  logic [15:0]            running_crc;

  logic [7:0]  hdr_view [HEADER_BYTES];
  logic        hdr_last;
  logic        sync_match;
  logic [15:0] hdr_len;
  logic [15:0] payload_count_inc;
  logic [15:0] crc_step;
  status_t     hdr_status;
  status_t     status;

  // On the last header byte the final byte is still in flight; fold it in.
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hdr_view[i] = header_store[i];
    end
    if (phase == PH_HEADER && hdr_last) begin
      hdr_view[HEADER_BYTES-1] = rx_byte;
    end
  end

  assign hdr_last          = (header_count == HDR_CNT_W'(HEADER_BYTES - 1));
  assign sync_match        = (rx_byte == cfg.sync_second);
  assign hdr_len           = {hdr_view[11], hdr_view[10]};
  assign payload_count_inc = payload_count + 16'd1;
  assign crc_step          = crc16_byte(running_crc, rx_byte);

  always_comb begin
    priority if (hdr_view[0] != cfg.protocol_version) begin
      hdr_status = ST_BAD_VER;
    end else if (hdr_view[1] != cfg.allowed_kind) begin
      hdr_status = ST_WRONG_TYP;
    end else if (hdr_len > cfg.max_payload) begin
      hdr_status = ST_TOO_LARGE;
    end else begin
      hdr_status = ST_NONE;
    end
  end

  // Next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SYNC2: begin
        if (sync_match) begin
          phase_next = PH_HEADER;
        end else if (rx_byte != cfg.sync_first) begin
          phase_next = PH_SYNC1;
        end
      end
      PH_HEADER: begin
        if (hdr_last) begin
          if (hdr_status != ST_NONE) begin
            phase_next = PH_SYNC1;
          end else if (hdr_len == 16'd0) begin
            phase_next = PH_CRC_LO;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (payload_count_inc >= hdr_len) begin
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: phase_next = PH_CRC_HI;
      PH_CRC_HI: phase_next = PH_SYNC1;
      default:   phase_next = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
    endcase
  end

  // Outputs
  always_comb begin
    status = ST_NONE;
    unique case (phase)
      PH_HEADER:  status = hdr_last ? hdr_status : ST_NONE;
      PH_CRC_HI:  status = ({rx_byte, crc_low_byte} == running_crc) ? ST_OK : ST_BAD_CRC;
      default:    status = ST_NONE;
    endcase

    result                = '0;
    result.status         = status;
    if (phase == PH_PAYLOAD) begin
      result.payload_valid = 1'b1;
      result.payload_byte  = rx_byte;
      result.payload_index = payload_count;
    end
    if (status != ST_NONE) begin
      result.version      = hdr_view[0];
      result.msg_kind     = hdr_view[1];
      result.peripheral   = hdr_view[2];
      result.res_code     = hdr_view[3];
      result.command_code = {hdr_view[5], hdr_view[4]};
      result.req_tag      = {hdr_view[9], hdr_view[8], hdr_view[7], hdr_view[6]};
      result.body_len     = hdr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      header_count  <= '0;
      payload_count <= '0;
      running_crc   <= CRC_INIT;
    end else if (accept) begin
      phase <= phase_next;
      unique case (phase)
        PH_SYNC2: begin
          if (sync_match) begin
            header_count <= '0;
            running_crc  <= CRC_INIT;
          end
        end
        PH_HEADER: begin
          running_crc  <= crc_step;
          header_count <= hdr_last ? '0 : header_count + HDR_CNT_W'(1);
          if (hdr_last) begin
            payload_count <= '0;
          end
        end
        PH_PAYLOAD: begin
          running_crc   <= crc_step;
          payload_count <= payload_count_inc;
        end
        default: ;
      endcase
    end
  end

  // Header bytes and CRC low byte, no reset
  always_ff @(posedge clk) begin
    if (accept && phase == PH_HEADER && header_count < HDR_CNT_W'(HEADER_BYTES)) begin
      header_store[header_count] <= rx_byte;
    end
    if (accept && phase == PH_CRC_LO) begin
      crc_low_byte <= rx_byte;
    end
  end

endmodule

FILE: design/sync_header_crc_frame_parser.sv
// Sync header / CRC16 frame parser, top level: stream ports, config registers,
// result register. Uses shcfp_pkg, shcfp_core and the assertion macro header.
//
// Usage:
//   s_* carries one received byte per beat. m_* returns one result beat per
//   input beat: a status code in tuser (nonzero on the last header byte of a
//   rejected frame and on the last CRC byte), a payload flag, and the payload
//   byte with its index, plus the header fields whenever status is nonzero.
//   cfg_* writes the sync bytes, accepted version and type, and max payload
//   length; cfg_ready is always high. Write only while the parser is idle.
//   A result beat comes from a register, in the cycle after its input beat.
//   Throughput is one byte per cycle while m_tready is high, set by the single
//   result register: s_tready is high when it is empty or drained this cycle.
//   If the receiver stalls, the result holds and s_tready drops until it is
//   taken. Reset (rst, synchronous) returns to sync hunting, empties the
//   result register, and loads default register values (0xAA, 0x55, 1, 0,
//   1024).
`include "sync_header_crc_frame_parser_macros.svh"

module sync_header_crc_frame_parser
  import shcfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,    // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,    // payload_byte, payload_index, version,
                                   // msg_kind, peripheral, res_code,
                                   // command_code, req_tag, body_len
  output logic [3:0]   m_tuser,    // [2:0] status, [3] payload_valid
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cfg_t    cfg;
  result_t core_result;
  result_t result;
  logic    in_accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first       <= 8'hAA;
      cfg.sync_second      <= 8'h55;
      cfg.protocol_version <= 8'd1;
      cfg.allowed_kind     <= 8'd0;
      cfg.max_payload      <= 16'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SYNC_FIRST:  cfg.sync_first       <= cfg_data[7:0];
        CFG_SYNC_SECOND: cfg.sync_second      <= cfg_data[7:0];
        CFG_VERSION:     cfg.protocol_version <= cfg_data[7:0];
        CFG_TYPE:        cfg.allowed_kind     <= cfg_data[7:0];
        CFG_MAX_PAYLOAD: cfg.max_payload      <= cfg_data;
        default: ;
      endcase
    end
  end

  shcfp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .rx_byte (s_tdata),
    .cfg     (cfg),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result <= core_result;
    end
  end

  assign m_tuser = {result.payload_valid, result.status};
  assign m_tdata = {result.body_len, result.req_tag, result.command_code,
                    result.res_code, result.peripheral, result.msg_kind,
                    result.version, result.payload_index, result.payload_byte};

  `SHCFP_ASSERT_NEXT(a_beat_gives_result, in_accept, m_tvalid, "accepted beat gave no result")
  `SHCFP_ASSERT_IMPLIES(a_payload_no_status, m_tvalid && result.payload_valid,
                        result.status == ST_NONE, "payload beat carries a status")
  `SHCFP_ASSERT_IMPLIES(a_quiet_header_zero, m_tvalid && result.status == ST_NONE,
                        result.req_tag == 32'd0 && result.body_len == 16'd0,
                        "header fields set without status")

endmodule
